### rtl/tpss_pkg.sv
// ---------------------------------------------------------------------------
// tpss_pkg
// Shared widths, register indexes and helper types for the pulse source.
// ---------------------------------------------------------------------------
package tpss_pkg;

   localparam int TIME_W  = 32;
   localparam int LEVEL_W = 16;
   localparam int ADDR_W  = 5;

   typedef enum logic [2:0] {
      REG_RAMP_LOW     = 3'd0,
      REG_RAMP_HIGH    = 3'd1,
      REG_RISE_TICKS   = 3'd2,
      REG_WIDTH_TICKS  = 3'd3,
      REG_FALL_TICKS   = 3'd4,
      REG_PERIOD_TICKS = 3'd5,
      REG_REF_TARGET   = 3'd6,
      REG_SETTLE_TICKS = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      SEG_LOW  = 2'd0,
      SEG_RISE = 2'd1,
      SEG_HIGH = 2'd2,
      SEG_FALL = 2'd3
   } segment_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] ramp_low;
      logic signed [LEVEL_W-1:0] ramp_high;
      logic [TIME_W-1:0]         rise_ticks;
      logic [TIME_W-1:0]         width_ticks;
      logic [TIME_W-1:0]         fall_ticks;
      logic [TIME_W-1:0]         period_ticks;
      logic signed [LEVEL_W-1:0] ref_target;
      logic [TIME_W-1:0]         settle_ticks;
   } cfg_type;

endpackage

### rtl/tpss_divpipe.sv
// ---------------------------------------------------------------------------
// tpss_divpipe
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module tpss_divpipe #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [DEN_W-1:0] out_rem,
   output logic [TAG_W-1:0] out_tag
);

   logic             vld_ff [NUM_W+1];
   logic [NUM_W-1:0] num_ff [NUM_W+1];
   logic [DEN_W-1:0] rem_ff [NUM_W+1];
   logic [DEN_W-1:0] den_ff [NUM_W+1];
   logic [TAG_W-1:0] tag_ff [NUM_W+1];

   always_comb begin
      vld_ff[0] = in_valid;
      num_ff[0] = in_num;
      rem_ff[0] = '0;
      den_ff[0] = in_den;
      tag_ff[0] = in_tag;
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W:0]   trial_in;
      logic [DEN_W:0]   diff_in;
      logic             vld_in;
      logic [NUM_W-1:0] num_in;
      logic [DEN_W-1:0] rem_in;
      logic             vld_stage_ff;
      logic [NUM_W-1:0] num_stage_ff;
      logic [DEN_W-1:0] rem_stage_ff;
      logic [DEN_W-1:0] den_stage_ff;
      logic [TAG_W-1:0] tag_stage_ff;

      always_comb begin
         trial_in = {rem_ff[s], num_ff[s][NUM_W-1]};
         diff_in  = trial_in - {1'b0, den_ff[s]};
         vld_in   = vld_ff[s];
         if (!diff_in[DEN_W]) begin
            rem_in = diff_in[DEN_W-1:0];
            num_in = {num_ff[s][NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial_in[DEN_W-1:0];
            num_in = {num_ff[s][NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_stage_ff <= 1'b0;
         end else begin
            vld_stage_ff <= vld_in;
         end
         num_stage_ff <= num_in;
         rem_stage_ff <= rem_in;
         den_stage_ff <= den_ff[s];
         tag_stage_ff <= tag_ff[s];
      end

      always_comb begin
         vld_ff[s+1] = vld_stage_ff;
         num_ff[s+1] = num_stage_ff;
         rem_ff[s+1] = rem_stage_ff;
         den_ff[s+1] = den_stage_ff;
         tag_ff[s+1] = tag_stage_ff;
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_quo   = num_ff[NUM_W];
   assign out_rem   = rem_ff[NUM_W];
   assign out_tag   = tag_ff[NUM_W];

endmodule

### rtl/tpss_csr.sv
// ---------------------------------------------------------------------------
// tpss_csr
// Register file behind the configuration port.
// ---------------------------------------------------------------------------
module tpss_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tpss_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output tpss_pkg::cfg_type             cfg
);
   import tpss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;
   logic    addr_ok;
   reg_index_type idx;

   assign pready  = 1'b1;
   assign idx     = reg_index_type'(paddr[ADDR_W-1:2]);
   assign addr_ok = (paddr[1:0] == 2'b00);
   assign wr_en   = psel && penable && pwrite && addr_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_RAMP_LOW:     cfg_in.ramp_low     = pwdata[LEVEL_W-1:0];
            REG_RAMP_HIGH:    cfg_in.ramp_high    = pwdata[LEVEL_W-1:0];
            REG_RISE_TICKS:   cfg_in.rise_ticks   = pwdata;
            REG_WIDTH_TICKS:  cfg_in.width_ticks  = pwdata;
            REG_FALL_TICKS:   cfg_in.fall_ticks   = pwdata;
            REG_PERIOD_TICKS: cfg_in.period_ticks = pwdata;
            REG_REF_TARGET:   cfg_in.ref_target   = pwdata[LEVEL_W-1:0];
            REG_SETTLE_TICKS: cfg_in.settle_ticks = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_low     <= '0;
         cfg_ff.ramp_high    <= '0;
         cfg_ff.rise_ticks   <= 32'd1;
         cfg_ff.width_ticks  <= 32'd1;
         cfg_ff.fall_ticks   <= 32'd1;
         cfg_ff.period_ticks <= 32'd1;
         cfg_ff.ref_target   <= '0;
         cfg_ff.settle_ticks <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (idx)
         REG_RAMP_LOW:     prdata = {{16{cfg_ff.ramp_low[15]}}, cfg_ff.ramp_low};
         REG_RAMP_HIGH:    prdata = {{16{cfg_ff.ramp_high[15]}}, cfg_ff.ramp_high};
         REG_RISE_TICKS:   prdata = cfg_ff.rise_ticks;
         REG_WIDTH_TICKS:  prdata = cfg_ff.width_ticks;
         REG_FALL_TICKS:   prdata = cfg_ff.fall_ticks;
         REG_PERIOD_TICKS: prdata = cfg_ff.period_ticks;
         REG_REF_TARGET:   prdata = {{16{cfg_ff.ref_target[15]}}, cfg_ff.ref_target};
         REG_SETTLE_TICKS: prdata = cfg_ff.settle_ticks;
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/trapezoid_pulse_and_soft_start_source_top.sv
// ---------------------------------------------------------------------------
// trapezoid_pulse_and_soft_start_source_top
// Periodic trapezoid level and soft-start reference from a tick time.
// ---------------------------------------------------------------------------
// pipeline: 32-stage modulo divider, 3 segment and product stages,
// 48-stage level divider, 1 output stage between start and rsp_valid
// throughput: one request per cycle, busy is held low
// reset: synchronous, clears pipeline valid bits and loads register defaults
// results cannot be stalled; each shows for one cycle on rsp_valid
module trapezoid_pulse_and_soft_start_source_top #(
   parameter int RAMP_DELAY_TICKS = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [31:0]                          req_time_ticks,
   output logic                                 rsp_valid,
   output logic signed [15:0]                   rsp_ramp_level,
   output logic signed [15:0]                   rsp_ref_level,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tpss_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import tpss_pkg::*;

   localparam int NUM_W = 48;
   localparam logic [33:0] DELAY = 34'(RAMP_DELAY_TICKS);

   cfg_type cfg;

   tpss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign busy = 1'b0;

   // stage a: phase = time mod period, time travels as tag
   logic        mod_valid;
   logic [31:0] mod_quo;
   logic [31:0] mod_rem;
   logic [31:0] mod_time;

   tpss_divpipe #(.NUM_W(32), .DEN_W(32), .TAG_W(32)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_num    (req_time_ticks),
      .in_den    (cfg.period_ticks),
      .in_tag    (req_time_ticks),
      .out_valid (mod_valid),
      .out_quo   (mod_quo),
      .out_rem   (mod_rem),
      .out_tag   (mod_time)
   );

   // stage b1: segment bounds
   logic        b1_valid_ff;
   logic [31:0] b1_phase_ff, b1_time_ff;
   logic [33:0] b1_rend_ff, b1_wend_ff;
   logic [31:0] phase_in;

   always_comb begin
      phase_in = (cfg.period_ticks != '0) ? mod_rem : mod_time;
      if (mod_quo == '1 && 1'b0) phase_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= mod_valid;
      end
      b1_phase_ff <= phase_in;
      b1_time_ff  <= mod_time;
      b1_rend_ff  <= DELAY + 34'(cfg.rise_ticks);
      b1_wend_ff  <= DELAY + 34'(cfg.rise_ticks) + 34'(cfg.width_ticks);
   end

   // stage b2: segment select and product operands
   logic        b2_valid_ff;
   segment_type b2_seg_ff;
   logic [31:0] b2_dt_ff, b2_den_ff;
   logic        b2_ref_hold_ff;
   logic [31:0] b2_time_ff;
   segment_type seg_in;
   logic [31:0] dt_in, den_in;
   logic [33:0] fend;
   logic [33:0] ph34;

   always_comb begin
      ph34  = 34'(b1_phase_ff);
      fend  = b1_wend_ff + 34'(cfg.fall_ticks);
      seg_in = SEG_LOW;
      dt_in  = '0;
      den_in = 32'd1;
      if (ph34 < DELAY) begin
         seg_in = SEG_LOW;
      end else if (ph34 < b1_rend_ff) begin
         seg_in = SEG_RISE;
         dt_in  = 32'(ph34 - DELAY);
         den_in = cfg.rise_ticks;
      end else if (ph34 < b1_wend_ff) begin
         seg_in = SEG_HIGH;
      end else if (ph34 < fend) begin
         seg_in = SEG_FALL;
         dt_in  = 32'(ph34 - b1_wend_ff);
         den_in = cfg.fall_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
      b2_seg_ff      <= seg_in;
      b2_dt_ff       <= dt_in;
      b2_den_ff      <= den_in;
      b2_time_ff     <= b1_time_ff;
      b2_ref_hold_ff <= !(b1_time_ff < cfg.settle_ticks);
   end

   // stage b3: magnitude products
   logic        b3_valid_ff;
   segment_type b3_seg_ff;
   logic [NUM_W-1:0] b3_rnum_ff, b3_snum_ff;
   logic [31:0] b3_den_ff;
   logic        b3_rneg_ff, b3_sneg_ff, b3_hold_ff;
   logic signed [16:0] span;
   logic [16:0] span_mag;
   logic [15:0] tgt_mag;

   always_comb begin
      span     = 17'(cfg.ramp_high) - 17'(cfg.ramp_low);
      span_mag = span[16] ? 17'(-span) : span;
      tgt_mag  = cfg.ref_target[15] ? 16'(-cfg.ref_target) : cfg.ref_target;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else begin
         b3_valid_ff <= b2_valid_ff;
      end
      b3_seg_ff  <= b2_seg_ff;
      b3_rnum_ff <= NUM_W'(span_mag) * NUM_W'(b2_dt_ff);
      b3_snum_ff <= NUM_W'(tgt_mag) * NUM_W'(b2_time_ff);
      b3_den_ff  <= b2_den_ff;
      b3_rneg_ff <= span[16];
      b3_sneg_ff <= cfg.ref_target[15];
      b3_hold_ff <= b2_ref_hold_ff;
   end

   // stage c: both divisions side by side
   localparam int TAG_W = 5;
   logic             rd_valid, sd_valid;
   logic [NUM_W-1:0] rd_quo, sd_quo;
   logic [31:0]      rd_rem, sd_rem;
   logic [TAG_W-1:0] rd_tag, sd_tag;

   tpss_divpipe #(.NUM_W(NUM_W), .DEN_W(32), .TAG_W(TAG_W)) u_rdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b3_valid_ff),
      .in_num    (b3_rnum_ff),
      .in_den    (b3_den_ff),
      .in_tag    ({b3_seg_ff, b3_rneg_ff, b3_sneg_ff, b3_hold_ff}),
      .out_valid (rd_valid),
      .out_quo   (rd_quo),
      .out_rem   (rd_rem),
      .out_tag   (rd_tag)
   );

   tpss_divpipe #(.NUM_W(NUM_W), .DEN_W(32), .TAG_W(TAG_W)) u_sdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b3_valid_ff),
      .in_num    (b3_snum_ff),
      .in_den    (cfg.settle_ticks),
      .in_tag    ({b3_seg_ff, b3_rneg_ff, b3_sneg_ff, b3_hold_ff}),
      .out_valid (sd_valid),
      .out_quo   (sd_quo),
      .out_rem   (sd_rem),
      .out_tag   (sd_tag)
   );

   // stage d: sign and level
   logic        d_valid_ff;
   logic signed [15:0] d_ramp_ff, d_ref_ff;
   logic signed [16:0] rq, sq;
   logic signed [15:0] ramp_in, ref_in;
   segment_type seg_d;

   always_comb begin
      seg_d = segment_type'(rd_tag[4:3]);
      rq = rd_tag[2] ? 17'(-$signed({1'b0, rd_quo[15:0]})) : $signed({1'b0, rd_quo[15:0]});
      sq = sd_tag[1] ? 17'(-$signed({1'b0, sd_quo[15:0]})) : $signed({1'b0, sd_quo[15:0]});
      case (seg_d)
         SEG_RISE: ramp_in = 16'(17'(cfg.ramp_low) + rq);
         SEG_HIGH: ramp_in = cfg.ramp_high;
         SEG_FALL: ramp_in = 16'(17'(cfg.ramp_high) - rq);
         default:  ramp_in = cfg.ramp_low;
      endcase
      ref_in = sd_tag[0] ? cfg.ref_target : sq[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= rd_valid && sd_valid;
      end
      d_ramp_ff <= ramp_in;
      d_ref_ff  <= ref_in;
   end

   assign rsp_valid      = d_valid_ff;
   assign rsp_ramp_level = d_ramp_ff;
   assign rsp_ref_level  = d_ref_ff;

   logic unused_bits;
   assign unused_bits = ^{rd_rem, sd_rem, rd_quo[NUM_W-1:16], sd_quo[NUM_W-1:16], sd_tag[4:2],
                          rd_tag[1:0]};

endmodule

### verif/trapezoid_pulse_and_soft_start_source_top_tb.sv
// ---------------------------------------------------------------------------
// trapezoid_pulse_and_soft_start_source_top_tb
// Drives tick times into the pulse source under several register settings,
// predicts both levels per request and checks every result in order.
// ---------------------------------------------------------------------------
module trapezoid_pulse_and_soft_start_source_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpss_pkg::*;

   localparam int DRAIN_CYCLES = 120;
   localparam longint CYCLE_LIMIT = 2000000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [31:0]               req_time_ticks = '0;
   logic                      rsp_valid;
   logic signed [15:0]        rsp_ramp_level;
   logic signed [15:0]        rsp_ref_level;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]         csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   typedef struct packed {
      logic signed [15:0] ramp;
      logic signed [15:0] refl;
   } levels_type;

   cfg_type     model_cfg;
   logic [31:0] time_queue[$];
   levels_type  level_queue[$];
   int          error_count = 0;
   longint      cycle_count = 0;
   bit          idle_free = 1'b0;

   trapezoid_pulse_and_soft_start_source_top #(.RAMP_DELAY_TICKS(0)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic levels_type predict_levels(logic [31:0] t);
      levels_type lv;
      longint unsigned phase, r_end, w_end, f_end;
      longint span;
      phase = (model_cfg.period_ticks != 0) ? t % model_cfg.period_ticks : t;
      r_end = model_cfg.rise_ticks;
      w_end = r_end + model_cfg.width_ticks;
      f_end = w_end + model_cfg.fall_ticks;
      span = longint'(model_cfg.ramp_high) - longint'(model_cfg.ramp_low);
      if (phase < r_end)
         lv.ramp = model_cfg.ramp_low + 16'(span * longint'(phase)
                   / longint'(model_cfg.rise_ticks));
      else if (phase < w_end)
         lv.ramp = model_cfg.ramp_high;
      else if (phase < f_end)
         lv.ramp = model_cfg.ramp_high - 16'(span * longint'(phase - w_end)
                   / longint'(model_cfg.fall_ticks));
      else
         lv.ramp = model_cfg.ramp_low;
      if (t < model_cfg.settle_ticks)
         lv.refl = 16'(longint'(model_cfg.ref_target) * longint'(t)
                   / longint'(model_cfg.settle_ticks));
      else
         lv.refl = model_cfg.ref_target;
      return lv;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("trapezoid_pulse_and_soft_start_source_top_tb: done, errors");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            level_queue.push_back(predict_levels(req_time_ticks));
            void'(time_queue.pop_front());
         end
         if (time_queue.size() > 0 && (idle_free || $urandom_range(99) >= 35)) begin
            start <= 1'b1;
            req_time_ticks <= time_queue[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      levels_type exp_lv;
      if (!reset && rsp_valid) begin
         if (level_queue.size() == 0) begin
            $error("unexpected result ramp_level %0d ref_level %0d",
                   rsp_ramp_level, rsp_ref_level);
            error_count = error_count + 1;
         end else begin
            exp_lv = level_queue.pop_front();
            if (rsp_ramp_level !== exp_lv.ramp) begin
               $error("ramp_level expected %0d actual %0d", exp_lv.ramp, rsp_ramp_level);
               error_count = error_count + 1;
            end
            if (rsp_ref_level !== exp_lv.refl) begin
               $error("ref_level expected %0d actual %0d", exp_lv.refl, rsp_ref_level);
               error_count = error_count + 1;
            end
         end
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_RAMP_LOW:     model_cfg.ramp_low = value[15:0];
         REG_RAMP_HIGH:    model_cfg.ramp_high = value[15:0];
         REG_RISE_TICKS:   model_cfg.rise_ticks = value;
         REG_WIDTH_TICKS:  model_cfg.width_ticks = value;
         REG_FALL_TICKS:   model_cfg.fall_ticks = value;
         REG_PERIOD_TICKS: model_cfg.period_ticks = value;
         REG_REF_TARGET:   model_cfg.ref_target = value[15:0];
         REG_SETTLE_TICKS: model_cfg.settle_ticks = value;
         default:          ;
      endcase
   endtask

   task automatic drain_requests();
      while (time_queue.size() != 0 || level_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_ticks(int mode);
      case (mode)
         0: return 32'($urandom_range(20));
         1: return 32'($urandom_range(2000));
         2: return $urandom;
         default: return (mode == 3) ? 32'hFFFF_FFFF : 32'd0;
      endcase
   endfunction

   task automatic write_all(logic [15:0] lo, logic [15:0] hi, logic [31:0] rise,
                            logic [31:0] wid, logic [31:0] fall, logic [31:0] per,
                            logic [15:0] tgt, logic [31:0] settle);
      write_reg(REG_RAMP_LOW, {{16{lo[15]}}, lo});
      write_reg(REG_RAMP_HIGH, {{16{hi[15]}}, hi});
      write_reg(REG_RISE_TICKS, rise);
      write_reg(REG_WIDTH_TICKS, wid);
      write_reg(REG_FALL_TICKS, fall);
      write_reg(REG_PERIOD_TICKS, per);
      write_reg(REG_REF_TARGET, {{16{tgt[15]}}, tgt});
      write_reg(REG_SETTLE_TICKS, settle);
   endtask

   initial begin
      int unsigned per_small;
      model_cfg = '{ramp_low: 0, ramp_high: 0, rise_ticks: 1, width_ticks: 1,
                    fall_ticks: 1, period_ticks: 1, ref_target: 0, settle_ticks: 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults then extremes and zero-length segments
      for (int i = 0; i < 4; i++) time_queue.push_back(32'(i));
      time_queue.push_back(32'hFFFF_FFFF);
      drain_requests();
      write_all(16'h8000, 16'h7FFF, 10, 5, 7, 30, 16'h8000, 100);
      for (int i = 0; i < 12; i++) time_queue.push_back(32'(i * 3));
      time_queue.push_back(32'd99);
      time_queue.push_back(32'd100);
      time_queue.push_back(32'hFFFF_FFFF);
      drain_requests();
      write_all(16'h7FFF, 16'h8000, 0, 0, 0, 0, 16'h7FFF, 32'hFFFF_FFFF);
      time_queue.push_back(32'd0);
      time_queue.push_back(32'd5);
      time_queue.push_back(32'hFFFF_FFFE);
      time_queue.push_back(32'hFFFF_FFFF);
      drain_requests();
      write_all(16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 16'h0001, 3);
      time_queue.push_back(32'h8000_0000);
      time_queue.push_back(32'hFFFF_FFFE);
      drain_requests();

      // random phases
      for (int ph = 0; ph < 12; ph++) begin
         write_all(16'($urandom), 16'($urandom), pick_ticks($urandom_range(4)),
                   pick_ticks($urandom_range(4)), pick_ticks($urandom_range(4)),
                   pick_ticks($urandom_range(3)), 16'($urandom),
                   pick_ticks($urandom_range(4)));
         idle_free = (ph == 5);
         per_small = model_cfg.period_ticks;
         for (int k = 0; k < 150; k++) begin
            if ($urandom_range(3) == 0 || per_small == 0 || per_small > 100000)
               time_queue.push_back($urandom);
            else
               time_queue.push_back($urandom_range(4 * per_small));
         end
         drain_requests();
      end

      if (error_count == 0)
         $display("trapezoid_pulse_and_soft_start_source_top_tb: done, clean");
      else
         $display("trapezoid_pulse_and_soft_start_source_top_tb: done, errors");
      $finish;
   end

endmodule
